>>> hw/rtl/pcpb_pkg.sv
// Shared types and constants for the coincidence position builder.
package pcpb_pkg;

	localparam int CH_BITS = 4;
	localparam int CNT_BITS = 32;
	localparam int TOT_BITS = 8;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [CFG_IDX_BITS-1:0] REG_TIMING_CH = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_TRIGGER_CH = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_KICKER_CH = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_LOW_THR = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_HIGH_THR = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_POS_MAP = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW = 3'd6;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic update;     // apply the captured hit to counters and group
		logic div_start;  // load both ratio dividers
		logic div_step;   // one quotient bit for both ratios
		logic out_load;   // move the result into the output register
	} pcpb_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic close;      // the captured hit closes a group
	} pcpb_sts_t;

endpackage

>>> hw/rtl/pmt_coincidence_position_builder.sv
// Top level of the PMT coincidence position builder.
// An accepted hit goes through the update state; a hit that closes a group then runs the
// bit-serial ratio dividers, waits until the output register is free and is loaded into it.
// No new hit is taken until the controller is back in idle, so hits never overlap.
// Reset: arst_n clears counters, flags and group state and loads config defaults at once.
module pmt_coincidence_position_builder import pcpb_pkg::*; #(
	parameter int TIME_BITS = 48,
	parameter int HEIGHT_BITS = 16,
	parameter int RATIO_FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	// Hit beats. s_tdata fields from bit 0: channel, pulse_height, timestamp.
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [((CH_BITS+HEIGHT_BITS+TIME_BITS+7)/8)*8-1:0] s_tdata,
	// Result beats. m_tdata fields from bit 0: height_a, height_b, height_c,
	// height_d, group_time, flight_time, hit_total, timing_total, kicker_total,
	// trigger_total, pos_x, pos_y.
	output logic m_tvalid,
	input  logic m_tready,
	output logic [((4*HEIGHT_BITS+2*TIME_BITS+1+TOT_BITS+3*CNT_BITS
		+2*(RATIO_FRAC_BITS+2)+7)/8)*8-1:0] m_tdata,
	// Configuration writes.
	input  logic cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_idx,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	localparam int RB = RATIO_FRAC_BITS + 2;
	localparam int OUT_RAW = 4*HEIGHT_BITS + 2*TIME_BITS + 1 + TOT_BITS + 3*CNT_BITS + 2*RB;
	localparam int OUT_W = ((OUT_RAW + 7) / 8) * 8;

	pcpb_cmd_t cmd;
	pcpb_sts_t sts;
	logic in_fire;
	logic [4*HEIGHT_BITS-1:0] r_heights;
	logic [TIME_BITS-1:0] r_group_time;
	logic [TIME_BITS:0] r_flight;
	logic [TOT_BITS-1:0] r_total;
	logic [CNT_BITS-1:0] r_timing, r_kicker, r_trigger;
	logic [RB-1:0] r_x, r_y;
	logic [OUT_W-1:0] out_q;
	logic out_valid_q;

	assign in_fire = s_tvalid && s_tready;

	pcpb_ctrl #(.STEPS(RB)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire),
		.out_busy(out_valid_q && !m_tready), .sts(sts),
		.s_ready(s_tready), .cmd(cmd)
	);

	pcpb_dp #(
		.TIME_BITS(TIME_BITS), .HEIGHT_BITS(HEIGHT_BITS),
		.RATIO_FRAC_BITS(RATIO_FRAC_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire),
		.in_channel(s_tdata[CH_BITS-1:0]),
		.in_height(s_tdata[CH_BITS +: HEIGHT_BITS]),
		.in_time(s_tdata[CH_BITS+HEIGHT_BITS +: TIME_BITS]),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.cmd(cmd), .sts(sts),
		.r_heights(r_heights), .r_group_time(r_group_time), .r_flight(r_flight),
		.r_total(r_total), .r_timing(r_timing), .r_kicker(r_kicker),
		.r_trigger(r_trigger), .r_x(r_x), .r_y(r_y)
	);

	// The output register holds one result while the core goes on with new hits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q <= OUT_W'({r_y, r_x, r_trigger, r_kicker, r_timing, r_total,
				r_flight, r_group_time, r_heights});
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid_q && !m_tready))
		else $error("result overwritten before taken");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");
	a_one_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> !s_tready)
		else $error("ready during update");

endmodule

>>> hw/rtl/pcpb_ctrl.sv
// Controller of the coincidence position builder: sequences hit update and division.
module pcpb_ctrl import pcpb_pkg::*; #(
	parameter int STEPS = 18
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_fire,
	input  logic      out_busy,
	input  pcpb_sts_t sts,
	output logic      s_ready,
	output pcpb_cmd_t cmd
);

	localparam int SC_BITS = $clog2(STEPS + 1);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_UPDATE = 5'b00010,
		ST_DIV    = 5'b00100,
		ST_WAIT   = 5'b01000,
		ST_LOAD   = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic [SC_BITS-1:0] step_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		s_ready = (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				if (sts.close) begin
					cmd.div_start = 1'b1;
					state_d = ST_DIV;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == SC_BITS'(STEPS - 1)) state_d = ST_WAIT;
			end
			ST_WAIT: begin
				if (!out_busy) state_d = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.out_load = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.div_start) step_q <= '0;
			else if (cmd.div_step) step_q <= step_q + 1'b1;
		end
	end

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("controller state not one-hot");
	a_div_after_close: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE && sts.close) |=> state_q == ST_DIV)
		else $error("close did not start division");
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !s_ready)
		else $error("second beat taken during processing");

endmodule

>>> hw/rtl/pcpb_dp.sv
// Datapath of the coincidence position builder: counters, group state and ratio dividers.
module pcpb_dp import pcpb_pkg::*; #(
	parameter int TIME_BITS = 48,
	parameter int HEIGHT_BITS = 16,
	parameter int RATIO_FRAC_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_fire,
	input  logic [CH_BITS-1:0]           in_channel,
	input  logic [HEIGHT_BITS-1:0]       in_height,
	input  logic [TIME_BITS-1:0]         in_time,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_BITS-1:0]      cfg_idx,
	input  logic [CFG_DATA_BITS-1:0]     cfg_data,
	input  pcpb_cmd_t                    cmd,
	output pcpb_sts_t                    sts,
	output logic [4*HEIGHT_BITS-1:0]     r_heights,
	output logic [TIME_BITS-1:0]         r_group_time,
	output logic [TIME_BITS:0]           r_flight,
	output logic [TOT_BITS-1:0]          r_total,
	output logic [CNT_BITS-1:0]          r_timing,
	output logic [CNT_BITS-1:0]          r_kicker,
	output logic [CNT_BITS-1:0]          r_trigger,
	output logic [RATIO_FRAC_BITS+1:0]   r_x,
	output logic [RATIO_FRAC_BITS+1:0]   r_y
);

	localparam int RB = RATIO_FRAC_BITS + 2;
	localparam int SB = HEIGHT_BITS + 1;
	localparam int NB = HEIGHT_BITS + RATIO_FRAC_BITS;

	logic [CH_BITS-1:0] tim_ch_q, trg_ch_q, kck_ch_q;
	logic [15:0] low_q, high_q, map_q, win_q;
	logic [CH_BITS-1:0] ch_q;
	logic [HEIGHT_BITS-1:0] h_q;
	logic [TIME_BITS-1:0] t_q;
	logic [CNT_BITS-1:0] tim_cnt_q, trg_cnt_q, kck_cnt_q;
	logic tim_seen_q, trg_seen_q;
	logic [TIME_BITS-1:0] ref_q, start_q;
	logic [HEIGHT_BITS-1:0] hgt_q [4];
	logic [TOT_BITS-1:0] hits_q [4];

	// Snapshot of the closed group.
	logic [HEIGHT_BITS-1:0] snap_h_q [4];
	logic [TIME_BITS-1:0] snap_start_q;
	logic [TIME_BITS:0] snap_flight_q;
	logic [TOT_BITS-1:0] snap_tot_q;
	logic [CNT_BITS-1:0] snap_tim_q, snap_kck_q, snap_trg_q;

	// Restoring dividers, one per ratio.
	logic [NB-1:0] xn_q, yn_q;
	logic [SB:0] xr_q, yr_q;
	logic [SB-1:0] xd_q, yd_q;
	logic [RB-1:0] xqt_q, yqt_q;
	logic xz_q, yz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tim_ch_q <= 4'd0;
			trg_ch_q <= 4'd1;
			kck_ch_q <= 4'd2;
			low_q <= 16'd0;
			high_q <= 16'hFFFF;
			map_q <= 16'h7654;
			win_q <= 16'd1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_TIMING_CH:  tim_ch_q <= cfg_data[CH_BITS-1:0];
				REG_TRIGGER_CH: trg_ch_q <= cfg_data[CH_BITS-1:0];
				REG_KICKER_CH:  kck_ch_q <= cfg_data[CH_BITS-1:0];
				REG_LOW_THR:    low_q <= cfg_data;
				REG_HIGH_THR:   high_q <= cfg_data;
				REG_POS_MAP:    map_q <= cfg_data;
				REG_WINDOW:     win_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			ch_q <= in_channel;
			h_q <= in_height;
			t_q <= in_time;
		end
	end

	// Reference pulse decode.
	logic in_win, is_tim, is_trg, is_kck;
	logic [CNT_BITS-1:0] tim_n, trg_n, kck_n;
	logic tseen_n, gseen_n, late;
	logic [TIME_BITS-1:0] diff;
	assign in_win = (16'(h_q) > low_q) && (16'(h_q) < high_q);
	assign is_tim = in_win && ch_q == tim_ch_q;
	assign is_trg = in_win && !is_tim && ch_q == trg_ch_q;
	assign is_kck = in_win && !is_tim && !is_trg && ch_q == kck_ch_q;
	assign tim_n = (is_tim && tim_cnt_q != '1) ? tim_cnt_q + 1'b1 : tim_cnt_q;
	assign trg_n = (is_trg && trg_cnt_q != '1) ? trg_cnt_q + 1'b1 : trg_cnt_q;
	assign kck_n = (is_kck && kck_cnt_q != '1) ? kck_cnt_q + 1'b1 : kck_cnt_q;
	assign tseen_n = tim_seen_q | is_tim;
	assign gseen_n = trg_seen_q | is_trg;
	assign diff = t_q - start_q;
	assign late = (t_q > start_q) && (diff > TIME_BITS'(win_q));
	assign sts.close = (tim_n != '0) && (late || tseen_n || gseen_n);

	logic [TIME_BITS-1:0] ref_n;
	assign ref_n = is_tim ? t_q : ref_q;

	// Position slot, lowest slot wins.
	logic [1:0] slot;
	logic slot_hit;
	always_comb begin
		slot = 2'd0;
		slot_hit = 1'b0;
		for (int i = 3; i >= 0; i--) begin
			if (map_q[4*i +: 4] == ch_q) begin
				slot = 2'(i);
				slot_hit = 1'b1;
			end
		end
	end

	logic [9:0] tot_sum;
	assign tot_sum = 10'(hits_q[0]) + 10'(hits_q[1]) + 10'(hits_q[2]) + 10'(hits_q[3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tim_cnt_q <= '0;
			trg_cnt_q <= '0;
			kck_cnt_q <= '0;
			tim_seen_q <= 1'b0;
			trg_seen_q <= 1'b0;
			ref_q <= '0;
			start_q <= '0;
			for (int i = 0; i < 4; i++) begin
				hgt_q[i] <= '0;
				hits_q[i] <= '0;
			end
		end else if (cmd.update) begin
			tim_cnt_q <= tim_n;
			trg_cnt_q <= trg_n;
			kck_cnt_q <= kck_n;
			ref_q <= ref_n;
			if (sts.close) begin
				tim_seen_q <= 1'b0;
				trg_seen_q <= 1'b0;
				start_q <= t_q;
				for (int i = 0; i < 4; i++) begin
					hgt_q[i] <= (slot_hit && slot == 2'(i)) ? h_q : '0;
					hits_q[i] <= (slot_hit && slot == 2'(i)) ? TOT_BITS'(1) : '0;
				end
			end else begin
				tim_seen_q <= tseen_n;
				trg_seen_q <= gseen_n;
				for (int i = 0; i < 4; i++) begin
					if (slot_hit && slot == 2'(i)) begin
						hgt_q[i] <= h_q;
						if (hits_q[i] != '1) hits_q[i] <= hits_q[i] + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update && sts.close) begin
			for (int i = 0; i < 4; i++) snap_h_q[i] <= hgt_q[i];
			snap_start_q <= start_q;
			snap_flight_q <= {1'b0, start_q} - {1'b0, ref_n};
			snap_tot_q <= (tot_sum > 10'd255) ? TOT_BITS'(255) : tot_sum[TOT_BITS-1:0];
			snap_tim_q <= tim_n;
			snap_kck_q <= kck_n;
			snap_trg_q <= trg_n;
		end
	end

	// Dividers: one quotient bit per step, RB steps. The top numerator bits can
	// never give a quotient bit, so they start out in the partial remainder and
	// only the low RB numerator bits are shifted in.
	logic [SB:0] xr_sh, yr_sh;
	assign xr_sh = {xr_q[SB-1:0], xn_q[NB-1]};
	assign yr_sh = {yr_q[SB-1:0], yn_q[NB-1]};

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			xn_q <= NB'({hgt_q[0], {RATIO_FRAC_BITS{1'b0}}} << (NB - RB));
			yn_q <= NB'({hgt_q[2], {RATIO_FRAC_BITS{1'b0}}} << (NB - RB));
			xd_q <= SB'(hgt_q[0]) + SB'(hgt_q[1]);
			yd_q <= SB'(hgt_q[2]) + SB'(hgt_q[3]);
			xz_q <= (hgt_q[0] == '0) && (hgt_q[1] == '0);
			yz_q <= (hgt_q[2] == '0) && (hgt_q[3] == '0);
			xr_q <= (SB+1)'(hgt_q[0] >> (RB - RATIO_FRAC_BITS));
			yr_q <= (SB+1)'(hgt_q[2] >> (RB - RATIO_FRAC_BITS));
			xqt_q <= '0;
			yqt_q <= '0;
		end else if (cmd.div_step) begin
			xn_q <= {xn_q[NB-2:0], 1'b0};
			yn_q <= {yn_q[NB-2:0], 1'b0};
			if (xr_sh >= {1'b0, xd_q}) begin
				xr_q <= xr_sh - {1'b0, xd_q};
				xqt_q <= {xqt_q[RB-2:0], 1'b1};
			end else begin
				xr_q <= xr_sh;
				xqt_q <= {xqt_q[RB-2:0], 1'b0};
			end
			if (yr_sh >= {1'b0, yd_q}) begin
				yr_q <= yr_sh - {1'b0, yd_q};
				yqt_q <= {yqt_q[RB-2:0], 1'b1};
			end else begin
				yr_q <= yr_sh;
				yqt_q <= {yqt_q[RB-2:0], 1'b0};
			end
		end
	end

	assign r_heights = {snap_h_q[3], snap_h_q[2], snap_h_q[1], snap_h_q[0]};
	assign r_group_time = snap_start_q;
	assign r_flight = snap_flight_q;
	assign r_total = snap_tot_q;
	assign r_timing = snap_tim_q;
	assign r_kicker = snap_kck_q;
	assign r_trigger = snap_trg_q;
	assign r_x = xz_q ? '1 : xqt_q;
	assign r_y = yz_q ? '1 : yqt_q;

	a_close_needs_timing: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.update && sts.close) |-> tim_n != '0)
		else $error("group closed before first timing pulse");
	a_close_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.update && sts.close) |=> !tim_seen_q && !trg_seen_q)
		else $error("seen flags not cleared on close");
	a_count_mono: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |=> tim_cnt_q >= $past(tim_cnt_q))
		else $error("timing count decreased");

endmodule

>>> test/tb_pmt_coincidence_position_builder.sv
// Testbench for the PMT coincidence position builder: hit stream in, closed groups out.
`timescale 1ns / 1ps

module tb_pmt_coincidence_position_builder;
	import pcpb_pkg::*;

	localparam int TIME_BITS = 48;
	localparam int HEIGHT_BITS = 16;
	localparam int FRAC_BITS = 16;
	localparam int S_BITS = ((CH_BITS + HEIGHT_BITS + TIME_BITS + 7) / 8) * 8;
	localparam int M_BITS = ((4*HEIGHT_BITS + 2*TIME_BITS + 1 + TOT_BITS + 3*CNT_BITS
		+ 2*(FRAC_BITS+2) + 7) / 8) * 8;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 30;

	// One hit as it travels on s_tdata, channel in the lowest bits.
	typedef struct packed {
		logic [TIME_BITS-1:0] stamp;
		logic [HEIGHT_BITS-1:0] height;
		logic [CH_BITS-1:0] chan;
	} hit_t;

	// One closed group as it travels on m_tdata, height_a in the lowest bits.
	typedef struct packed {
		logic [FRAC_BITS+1:0] pos_y;
		logic [FRAC_BITS+1:0] pos_x;
		logic [CNT_BITS-1:0] trigger_total;
		logic [CNT_BITS-1:0] kicker_total;
		logic [CNT_BITS-1:0] timing_total;
		logic [TOT_BITS-1:0] hit_total;
		logic [TIME_BITS:0] flight_time;
		logic [TIME_BITS-1:0] group_time;
		logic [HEIGHT_BITS-1:0] height_d;
		logic [HEIGHT_BITS-1:0] height_c;
		logic [HEIGHT_BITS-1:0] height_b;
		logic [HEIGHT_BITS-1:0] height_a;
	} group_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_BITS-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_BITS-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_idx = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	pmt_coincidence_position_builder u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Shadow copy of the register file, indexed by the package register codes.
	logic [CFG_DATA_BITS-1:0] shadow_reg [7];

	// Shadow copy of the counters and of the open group.
	logic [CNT_BITS-1:0] timing_cnt, trigger_cnt, kicker_cnt;
	logic timing_flag, trigger_flag;
	logic [TIME_BITS-1:0] ref_time, start_time;
	logic [HEIGHT_BITS-1:0] slot_height [4];
	logic [TOT_BITS-1:0] slot_hits [4];

	hit_t pending_hits [$];
	group_t expected_groups [$];
	hit_t hit_on_bus;
	int tx_gap = 0;
	int rx_gap = 0;
	bit tx_idle = 1'b0;
	bit rx_idle = 1'b0;
	int mismatches = 0;
	int cycles = 0;
	logic [TIME_BITS-1:0] now_t = '0;

	// Charge-division ratio in Q2.16; an all-ones code stands for an empty pair.
	function automatic logic [FRAC_BITS+1:0] charge_ratio(logic [HEIGHT_BITS-1:0] num,
		logic [HEIGHT_BITS-1:0] other);
		logic [HEIGHT_BITS:0] sum;
		logic [HEIGHT_BITS+FRAC_BITS:0] wide;
		sum = {1'b0, num} + {1'b0, other};
		if (sum == 0)
			return '1;
		wide = {1'b0, num, {FRAC_BITS{1'b0}}} / sum;
		return wide[FRAC_BITS+1:0];
	endfunction

	function automatic logic [CNT_BITS-1:0] bump(logic [CNT_BITS-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// Applies one accepted hit to the shadow state. Returns 1 when the hit closes
	// the open group, with the closed group in res.
	function automatic bit close_group_on_hit(hit_t h, output group_t res);
		bit in_win;
		bit closes;
		int total;
		int slot;
		in_win = h.height > shadow_reg[REG_LOW_THR] && h.height < shadow_reg[REG_HIGH_THR];
		res = '0;
		// A hit matching several reference channels counts once, timing first.
		if (in_win && h.chan == shadow_reg[REG_TIMING_CH][CH_BITS-1:0]) begin
			timing_cnt = bump(timing_cnt);
			ref_time = h.stamp;
			timing_flag = 1'b1;
		end else if (in_win && h.chan == shadow_reg[REG_TRIGGER_CH][CH_BITS-1:0]) begin
			trigger_cnt = bump(trigger_cnt);
			trigger_flag = 1'b1;
		end else if (in_win && h.chan == shadow_reg[REG_KICKER_CH][CH_BITS-1:0]) begin
			kicker_cnt = bump(kicker_cnt);
		end
		// A hit earlier than the group start never counts as outside the window.
		closes = timing_cnt != 0 && ((h.stamp > start_time &&
			(h.stamp - start_time) > shadow_reg[REG_WINDOW]) || timing_flag || trigger_flag);
		if (closes) begin
			total = slot_hits[0] + slot_hits[1] + slot_hits[2] + slot_hits[3];
			res.height_a = slot_height[0];
			res.height_b = slot_height[1];
			res.height_c = slot_height[2];
			res.height_d = slot_height[3];
			res.group_time = start_time;
			res.flight_time = {1'b0, start_time} - {1'b0, ref_time};
			res.hit_total = (total > 255) ? 8'd255 : total[7:0];
			res.timing_total = timing_cnt;
			res.kicker_total = kicker_cnt;
			res.trigger_total = trigger_cnt;
			res.pos_x = charge_ratio(slot_height[0], slot_height[1]);
			res.pos_y = charge_ratio(slot_height[2], slot_height[3]);
			timing_flag = 1'b0;
			trigger_flag = 1'b0;
			for (int i = 0; i < 4; i++) begin
				slot_height[i] = '0;
				slot_hits[i] = '0;
			end
			start_time = h.stamp;
		end
		// The closing hit may open the new group; duplicate map entries go to the lowest slot.
		slot = -1;
		for (int i = 3; i >= 0; i--)
			if (shadow_reg[REG_POS_MAP][4*i +: 4] == h.chan)
				slot = i;
		if (slot >= 0) begin
			if (slot_hits[slot] != 8'd255)
				slot_hits[slot] = slot_hits[slot] + 1'b1;
			slot_height[slot] = h.height;
		end
		return closes;
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Sender: holds a beat until it is taken, then loads the next pending hit.
	always @(posedge clk or negedge arst_n) begin
		group_t res;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!(s_tvalid && !s_tready)) begin
			if (s_tvalid && close_group_on_hit(hit_on_bus, res))
				expected_groups.push_back(res);
			if (tx_gap > 0) begin
				tx_gap <= tx_gap - 1;
				s_tvalid <= 1'b0;
			end else if (pending_hits.size() > 0) begin
				hit_on_bus = pending_hits.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {{(S_BITS-$bits(hit_t)){1'b0}}, hit_on_bus};
				if (tx_idle && $urandom_range(0, 2) == 0)
					tx_gap <= rand_gap();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: checks every taken result beat field by field against the oldest group.
	always @(posedge clk or negedge arst_n) begin
		group_t got, want;
		logic [63:0] got_f [12];
		logic [63:0] want_f [12];
		string names [12];
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[$bits(group_t)-1:0];
				if (expected_groups.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat %h", got);
				end else begin
					want = expected_groups.pop_front();
					names = '{"height_a", "height_b", "height_c", "height_d", "group_time",
						"flight_time", "hit_total", "timing_total", "kicker_total",
						"trigger_total", "pos_x", "pos_y"};
					got_f = '{got.height_a, got.height_b, got.height_c, got.height_d,
						got.group_time, got.flight_time, got.hit_total, got.timing_total,
						got.kicker_total, got.trigger_total, got.pos_x, got.pos_y};
					want_f = '{want.height_a, want.height_b, want.height_c, want.height_d,
						want.group_time, want.flight_time, want.hit_total, want.timing_total,
						want.kicker_total, want.trigger_total, want.pos_x, want.pos_y};
					for (int i = 0; i < 12; i++)
						if (got_f[i] !== want_f[i]) begin
							mismatches++;
							if (mismatches <= 10)
								$display("%s mismatch: expected %h, got %h", names[i],
									want_f[i], got_f[i]);
						end
				end
			end
			if (rx_gap > 0) begin
				rx_gap <= rx_gap - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (rx_idle && $urandom_range(0, 2) == 0)
					rx_gap <= rand_gap();
			end
		end
	end

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Waits until every queued hit is taken and every group has come back, then lets
	// the block finish any hit whose work produces no result.
	task automatic drain();
		while (pending_hits.size() != 0 || s_tvalid || expected_groups.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes all seven registers; only called while the block is idle.
	task automatic load_regs(logic [3:0] t_ch, logic [3:0] g_ch, logic [3:0] k_ch,
		logic [15:0] low, logic [15:0] high, logic [15:0] map, logic [15:0] win);
		logic [15:0] vals [7];
		vals = '{{12'd0, t_ch}, {12'd0, g_ch}, {12'd0, k_ch}, low, high, map, win};
		for (int i = 0; i < 7; i++) begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_idx <= i[CFG_IDX_BITS-1:0];
			cfg_data <= vals[i];
			shadow_reg[i] = vals[i];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic void add_hit(logic [3:0] ch, logic [15:0] h, logic [47:0] t);
		hit_t x;
		x.chan = ch;
		x.height = h;
		x.stamp = t;
		pending_hits.push_back(x);
	endfunction

	// A height that passes the reference window when the window is not empty.
	function automatic logic [15:0] pulse_height();
		if (int'(shadow_reg[REG_LOW_THR]) + 1 < int'(shadow_reg[REG_HIGH_THR]))
			return 16'($urandom_range(shadow_reg[REG_LOW_THR] + 1,
				shadow_reg[REG_HIGH_THR] - 1));
		return 16'($urandom);
	endfunction

	// Mostly a plausible detector stream in rising time, with some noise mixed in.
	function automatic void add_random_hit();
		int r, rt;
		logic [3:0] ch;
		logic [15:0] h;
		logic [47:0] t;
		r = $urandom_range(0, 99);
		h = 16'($urandom);
		if (r < 35) begin
			ch = shadow_reg[REG_POS_MAP][4*$urandom_range(0, 3) +: 4];
			if ($urandom_range(0, 9) == 0)
				h = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
		end else if (r < 50) begin
			ch = shadow_reg[REG_TIMING_CH][3:0];
			h = pulse_height();
		end else if (r < 62) begin
			ch = shadow_reg[REG_TRIGGER_CH][3:0];
			h = pulse_height();
		end else if (r < 72) begin
			ch = shadow_reg[REG_KICKER_CH][3:0];
			h = pulse_height();
		end else begin
			ch = 4'($urandom);
		end
		rt = $urandom_range(0, 99);
		if (rt < 4)
			now_t = 48'({$urandom, $urandom});
		else if (rt < 10)
			now_t = now_t - 48'($urandom_range(1, 20));
		else
			now_t = now_t + 48'($urandom_range(0, 2 * int'(shadow_reg[REG_WINDOW]) + 3));
		t = now_t;
		add_hit(ch, h, t);
	endfunction

	initial begin
		timing_cnt = '0;
		trigger_cnt = '0;
		kicker_cnt = '0;
		timing_flag = 1'b0;
		trigger_flag = 1'b0;
		ref_time = '0;
		start_time = '0;
		for (int i = 0; i < 4; i++) begin
			slot_height[i] = '0;
			slot_hits[i] = '0;
		end
		shadow_reg = '{16'd0, 16'd1, 16'd2, 16'd0, 16'hFFFF, 16'h7654, 16'd1};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset settings: A=4, B=5, C=6, D=7, window 1.
		add_hit(4'd4, 16'd100, 48'd5);      // fills the group before any timing pulse
		add_hit(4'd5, 16'd0, 48'd5);
		add_hit(4'd0, 16'd200, 48'd6);      // first timing pulse closes; pos_x is full scale
		add_hit(4'd6, 16'hFFFF, 48'd6);
		add_hit(4'd7, 16'hFFFF, 48'd6);
		add_hit(4'd1, 16'hFFFF, 48'd7);     // height at the upper threshold does not count
		add_hit(4'd1, 16'd500, 48'd7);      // trigger closes; empty A/B pair gives the all-ones code
		add_hit(4'd2, 16'd0, 48'd7);        // height at the lower threshold does not count
		add_hit(4'd2, 16'd1, 48'd7);        // kicker counts, never closes
		add_hit(4'd4, 16'd10, 48'd3);       // earlier than group start: stays open
		add_hit(4'd4, 16'd20, 48'd10);      // beyond the window: closes
		add_hit(4'd9, 16'd7, 48'hFFFF_FFFF_FFFF);
		add_hit(4'd4, 16'hFFFE, 48'd0);
		add_hit(4'd0, 16'hFFFE, 48'd0);     // reference time back to zero
		add_hit(4'd0, 16'd1, 48'h8000_0000_0000); // negative time of flight follows
		add_hit(4'd15, 16'd0, 48'h8000_0000_0000);
		add_hit(4'd5, 16'h5555, 48'h8000_0000_0001);
		add_hit(4'd6, 16'hAAAA, 48'h8000_0000_0001);
		add_hit(4'd7, 16'h1234, 48'h8000_0000_0001);
		add_hit(4'd1, 16'd9, 48'h8000_0000_0001);
		drain();

		// Random phases, each under its own settings, with a pause to empty now and then.
		for (int p = 0; p < 7; p++) begin
			tx_idle = (p % 3) != 0;
			rx_idle = (p % 3) != 1;
			case (p)
			0: load_regs(4'd0, 4'd1, 4'd2, 16'd0, 16'hFFFF, 16'h7654, 16'd1);
			// All map slots and two reference roles on one channel; window closed.
			1: load_regs(4'd15, 4'd15, 4'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
			// Empty reference window: only time closes groups.
			2: load_regs(4'd3, 4'd8, 4'd9, 16'hFFFF, 16'h0000, 16'h3210, 16'hFFFF);
			default: load_regs(4'($urandom), 4'($urandom), 4'($urandom),
				16'($urandom_range(0, 30000)), 16'($urandom_range(30001, 65535)),
				16'($urandom), 16'($urandom_range(0, 200)));
			endcase
			for (int n = 0; n < 200; n++) begin
				add_random_hit();
				if (n % 50 == 49)
					drain();
			end
			drain();
		end

		// Saturate the group hit total inside one very wide window.
		tx_idle = 1'b0;
		rx_idle = 1'b1;
		load_regs(4'd0, 4'd1, 4'd2, 16'd0, 16'hFFFF, 16'h7654, 16'hFFFF);
		add_hit(4'd0, 16'd50, 48'd1000);
		for (int n = 0; n < 300; n++)
			add_hit(4'd4 + n[1:0], 16'($urandom), 48'd1000 + n);
		add_hit(4'd1, 16'd50, 48'd1400);
		drain();

		if (mismatches == 0 && expected_groups.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/pcpb_pkg.sv
hw/rtl/pcpb_ctrl.sv
hw/rtl/pcpb_dp.sv
hw/rtl/pmt_coincidence_position_builder.sv
test/tb_pmt_coincidence_position_builder.sv
